### hw/rtl/ogi_pkg.sv
// ----------------------------------------------------------------------------
// ogi_pkg: shared constants for the occupancy grid inflation block
// Field widths, stream packing, register indexes, function codes, reset values,
// cell flag encodings and result bit positions.
`default_nettype none

package ogi_pkg;

    // Fixed field widths of one transaction.
    localparam int COORD_W = 7;
    localparam int VALUE_W = 8;
    localparam int CFG_W   = 8;

    // Stream packing: input tdata holds col, row, cell_value from bit 0 up,
    // padded to whole bytes. Output tdata holds blocked, own_nonzero.
    localparam int S_TDATA_W = ((2 * COORD_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 1'b1;

    // Function codes carried in tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Reset values of the grid size registers.
    localparam logic [CFG_W-1:0] COLUMNS_RESET = 8'd100;
    localparam logic [CFG_W-1:0] ROWS_RESET    = 8'd100;

    // Cell values that mark an inflation source.
    localparam logic [VALUE_W-1:0] OCCUPIED_VALUE = 8'd100;
    localparam logic [VALUE_W-1:0] UNKNOWN_VALUE  = 8'hFF;

    // Flag bits stored per cell.
    localparam int FLAG_W          = 2;
    localparam int FLAG_NONZERO_BIT = 0;
    localparam int FLAG_SOURCE_BIT  = 1;

    // Result bit positions in the output tdata.
    localparam int RES_BLOCKED_BIT = 0;
    localparam int RES_OWN_BIT     = 1;

endpackage

`default_nettype wire

### hw/rtl/occupancy_grid_obstacle_inflation.sv
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_inflation: occupancy grid with obstacle inflation
// Stores two flag bits per grid cell and answers blocked/free queries.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries one transaction
// per item. tuser selects a cell write or a cell query; tdata carries the
// column, row and cell value. A write is stored in the cycle it is accepted
// and produces no result; the block is ready again in the next cycle.
// A query returns one result transaction on the master stream (m_tvalid/
// m_tready/m_tdata): blocked and own_nonzero. A query inside the grid reads
// the (2*RADIUS+1)^2 window cells from one single-port memory, one read per
// cycle; that memory port sets the rate. A query outside the grid skips the
// window reads and is reported blocked. The block accepts no input while a
// query is in progress.
// The result sits in an output register, so a stalled receiver only holds
// the block once a second result is ready to be loaded behind it.
// After reset the flag memory is cleared by a sweep over all cells
// (MAX_ROWS * MAX_COLS), during which s_tready stays low; the configuration
// channel accepts writes at all times, and the grid size registers return
// to 100 x 100.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_obstacle_inflation #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128,
    parameter int RADIUS   = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: col [6:0], row [13:7], cell_value [21:14], zero pad [23:22]
    input  wire logic [ogi_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: func (0 write, 1 query)
    input  wire logic                            s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tdata: blocked [0], own_nonzero [1], zero pad [7:2]
    output logic      [ogi_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ogi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ogi_pkg::CFG_W-1:0]       cfg_data
);

    import ogi_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WC     = $clog2(MAX_COLS + 1);
    localparam int WR     = $clog2(MAX_ROWS + 1);
    // Signed neighbor coordinate: index plus or minus RADIUS.
    localparam int NW     = $clog2((1 << COORD_W) + RADIUS) + 1;
    localparam int OFS_W  = $clog2(2 * RADIUS + 2);
    localparam int M1     = (WC > WR) ? WC : WR;
    localparam int M2     = (NW > CFG_W) ? NW : CFG_W;
    // Common compare width for grid bounds checks.
    localparam int CW     = ((M1 > M2) ? M1 : M2) + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]    columns_reg, columns_next;
    logic [CFG_W-1:0]    rows_reg, rows_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [OFS_W-1:0]    dr_reg, dr_next;
    logic [OFS_W-1:0]    dc_reg, dc_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_center_reg, pend_center_next;
    logic                blocked_reg, blocked_next;
    logic                own_reg, own_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_blocked_reg, out_blocked_next;
    logic                out_own_reg, out_own_next;

    // Input fields.
    logic [COORD_W-1:0]  in_col;
    logic [COORD_W-1:0]  in_row;
    logic [VALUE_W-1:0]  in_value;
    logic                in_func;
    logic [FLAG_W-1:0]   in_flags;
    logic                in_grid;
    logic [ADDR_W-1:0]   in_addr;

    // Active grid size, capped at the memory dimensions.
    logic [CW-1:0]       cols_ext, rows_ext;
    logic [CW-1:0]       cols_act, rows_act;

    // Current window position.
    logic [NW-1:0]       nb_row, nb_col;
    logic                nb_valid;
    logic                nb_center;
    logic                scan_last;
    logic [ADDR_W-1:0]   nb_addr;

    // Memory port.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [FLAG_W-1:0]   ram_wdata;
    logic [FLAG_W-1:0]   ram_rdata;

    assign in_col   = s_tdata[COORD_W-1:0];
    assign in_row   = s_tdata[2*COORD_W-1:COORD_W];
    assign in_value = s_tdata[2*COORD_W+VALUE_W-1:2*COORD_W];
    assign in_func  = s_tuser;

    assign in_flags[FLAG_NONZERO_BIT] = (in_value != '0);
    assign in_flags[FLAG_SOURCE_BIT]  = (in_value == OCCUPIED_VALUE) ||
                                        (in_value == UNKNOWN_VALUE);

    assign cols_ext = CW'(columns_reg);
    assign rows_ext = CW'(rows_reg);
    assign cols_act = (cols_ext > CW'(MAX_COLS)) ? CW'(MAX_COLS) : cols_ext;
    assign rows_act = (rows_ext > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : rows_ext;

    assign in_grid = (CW'(in_col) < cols_act) && (CW'(in_row) < rows_act);
    assign in_addr = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_col));

    // The window offset counters run from 0 to 2*RADIUS; subtracting RADIUS
    // gives the signed neighbor position, negative values wrap to a set MSB.
    assign nb_row   = NW'(row_reg) + NW'(dr_reg) - NW'(RADIUS);
    assign nb_col   = NW'(col_reg) + NW'(dc_reg) - NW'(RADIUS);
    assign nb_valid = !nb_row[NW-1] && !nb_col[NW-1] &&
                      (CW'(nb_row) < rows_act) && (CW'(nb_col) < cols_act);
    assign nb_center = (dr_reg == OFS_W'(RADIUS)) && (dc_reg == OFS_W'(RADIUS));
    assign scan_last = (dr_reg == OFS_W'(2 * RADIUS)) && (dc_reg == OFS_W'(2 * RADIUS));
    assign nb_addr  = ADDR_W'(ADDR_W'(nb_row) * ADDR_W'(MAX_COLS) + ADDR_W'(nb_col));

    // Memory port selection: clearing sweep, cell writes, window reads.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = nb_addr;
        ram_wdata = in_flags;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_we   = s_tvalid && (in_func == FUNC_WRITE) && in_grid;
                ram_addr = in_addr;
            end
            default:
            begin
                ram_we   = 1'b0;
                ram_addr = nb_addr;
            end
        endcase
    end

    ogi_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (DEPTH)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        columns_next     = columns_reg;
        rows_next        = rows_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        dr_next          = dr_reg;
        dc_next          = dc_reg;
        pend_valid_next  = pend_valid_reg;
        pend_center_next = pend_center_reg;
        blocked_next     = blocked_reg;
        own_next         = own_reg;
        out_valid_next   = out_valid_reg;
        out_blocked_next = out_blocked_reg;
        out_own_next     = out_own_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_COLUMNS_IN_USE: columns_next = cfg_data;
                REG_ROWS_IN_USE:    rows_next    = cfg_data;
                default:            columns_next = columns_reg;
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // Read data of the previous window cycle arrives here.
        if ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        begin
            if (pend_valid_reg && ram_rdata[FLAG_SOURCE_BIT])
            begin
                blocked_next = 1'b1;
            end
            if (pend_center_reg)
            begin
                own_next = ram_rdata[FLAG_NONZERO_BIT];
                if (ram_rdata[FLAG_NONZERO_BIT])
                begin
                    blocked_next = 1'b1;
                end
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && (in_func == FUNC_QUERY))
                begin
                    col_next         = in_col;
                    row_next         = in_row;
                    dr_next          = '0;
                    dc_next          = '0;
                    pend_valid_next  = 1'b0;
                    pend_center_next = 1'b0;
                    own_next         = 1'b0;
                    if (in_grid)
                    begin
                        blocked_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        blocked_next = 1'b1;
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_valid_next  = nb_valid;
                pend_center_next = nb_center;
                if (dc_reg == OFS_W'(2 * RADIUS))
                begin
                    dc_next = '0;
                    dr_next = dr_reg + 1'b1;
                end
                else
                begin
                    dc_next = dc_reg + 1'b1;
                end
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                pend_valid_next  = 1'b0;
                pend_center_next = 1'b0;
                state_next       = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_blocked_next = blocked_reg;
                    out_own_next     = own_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            columns_reg     <= COLUMNS_RESET;
            rows_reg        <= ROWS_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            dr_reg          <= '0;
            dc_reg          <= '0;
            pend_valid_reg  <= 1'b0;
            pend_center_reg <= 1'b0;
            blocked_reg     <= 1'b0;
            own_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_blocked_reg <= 1'b0;
            out_own_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            columns_reg     <= columns_next;
            rows_reg        <= rows_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            dr_reg          <= dr_next;
            dc_reg          <= dc_next;
            pend_valid_reg  <= pend_valid_next;
            pend_center_reg <= pend_center_next;
            blocked_reg     <= blocked_next;
            own_reg         <= own_next;
            out_valid_reg   <= out_valid_next;
            out_blocked_reg <= out_blocked_next;
            out_own_reg     <= out_own_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        m_tdata                  = '0;
        m_tdata[RES_BLOCKED_BIT] = out_blocked_reg;
        m_tdata[RES_OWN_BIT]     = out_own_reg;
    end

endmodule

`default_nettype wire

### hw/rtl/ogi_ram.sv
// ----------------------------------------------------------------------------
// ogi_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ogi_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### hw/rtl/ogi_checker.sv
// ----------------------------------------------------------------------------
// ogi_checker: port-level checks for the occupancy grid inflation block
// Watches the stream ports and flags sequencing or result encoding errors.
// ----------------------------------------------------------------------------
`default_nettype none

module ogi_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [ogi_pkg::M_TDATA_W-1:0]   m_tdata
);

    import ogi_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A query keeps the block busy for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_QUERY) |=> !s_tready)
        else $error("block ready right after a query transaction");

    // A write completes in the cycle it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_WRITE) |=> s_tready)
        else $error("block busy after a write transaction");

    // A cell that is nonzero itself is always reported blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[RES_BLOCKED_BIT] || !m_tdata[RES_OWN_BIT]))
        else $error("own_nonzero set without blocked");

    // Padding bits of the result stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:RES_OWN_BIT+1] == '0))
        else $error("result padding bits not zero");

endmodule

bind occupancy_grid_obstacle_inflation ogi_checker u_ogi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
